// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file lkvc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== design/lkvc_pkg.sv =====
// Package with constants and types of the LRU key-value cache.
package lkvc_pkg;

    localparam int CAP       = 8;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int KEY_W     = 16;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CAP_RESET = (CAP < 8) ? CAP : 8;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef struct packed {
        func_t                    func;
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
        logic                     evicted;
        logic [KEY_W-1:0]         evicted_key;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic                     hit;
        logic                     full;
        logic [KEY_W-1:0]         key;
    } cell_ctrl_t;

endpackage

// ===== design/lkvc_cell.sv =====
// One recency slot of the cache: holds an entry and shifts in its neighbor's entry.
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  logic        pass_in,
    input  entry_t      up_entry,
    input  logic        up_valid,
    input  logic        down_valid,
    output logic        pass_out,
    output entry_t      entry,
    output logic        valid,
    output logic        match,
    output logic        tail
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    always_comb
    begin
        match    = valid_reg && (entry_reg.key == ctrl.key);
        tail     = valid_reg && !down_valid;
        pass_out = pass_in && (ctrl.hit ? !match : (ctrl.full ? !tail : valid_reg));
        entry_next = pass_in ? up_entry : entry_reg;
        valid_next = pass_in ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// ===== design/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: request register, cell chain and result register.
// An accepted request is captured in the request register and sets busy; its result is then registered with done.
// A new request is not taken while busy is high; busy is high in the cycle the cell chain updates.
// The cell chain keeps entries in recency order and shifts them as a request updates it.
// Reset empties the cache and sets capacity to its full value; results cannot be stalled.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output logic              done,
    output rsp_t              rsp
);

    req_t              req_reg;
    logic              busy_reg;
    logic              done_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic [CNT_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  capacity_next;
    logic [CNT_W-1:0]  occupied_reg;
    logic [CNT_W-1:0]  occupied_next;

    cell_ctrl_t        ctrl;
    entry_t            head_entry;
    entry_t            cell_entry [CAP];
    logic [CAP-1:0]    cell_valid;
    logic [CAP-1:0]    cell_match;
    logic [CAP-1:0]    cell_tail;
    logic [CAP-1:0]    pass;

    logic                     hit;
    logic                     full;
    logic                     is_put;
    logic signed [VAL_W-1:0]  hit_value;
    logic [KEY_W-1:0]         tail_key;

    assign hit    = |cell_match;
    assign full   = (occupied_reg >= capacity_reg);
    assign is_put = (req_reg.func == FUNC_PUT);

    always_comb
    begin
        hit_value = '0;
        tail_key  = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (cell_match[i])
            begin
                hit_value = hit_value | cell_entry[i].value;
            end
            if (cell_tail[i])
            begin
                tail_key = tail_key | cell_entry[i].key;
            end
        end
    end

    always_comb
    begin
        ctrl.hit         = hit;
        ctrl.full        = full;
        ctrl.key         = req_reg.key;
        head_entry.key   = req_reg.key;
        head_entry.value = (hit && !is_put) ? hit_value : req_reg.value;
    end

    assign pass[0] = busy_reg && (hit || is_put);

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        entry_t up_entry;
        logic   up_valid;
        logic   down_valid;

        if (i == 0)
        begin : g_head
            assign up_entry = head_entry;
            assign up_valid = 1'b1;
        end
        else
        begin : g_body
            assign up_entry = cell_entry[i-1];
            assign up_valid = cell_valid[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign down_valid = 1'b0;
            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .pass_in    (pass[i]),
                .up_entry   (up_entry),
                .up_valid   (up_valid),
                .down_valid (down_valid),
                .pass_out   (),
                .entry      (cell_entry[i]),
                .valid      (cell_valid[i]),
                .match      (cell_match[i]),
                .tail       (cell_tail[i])
            );
        end
        else
        begin : g_mid
            assign down_valid = cell_valid[i+1];
            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .pass_in    (pass[i]),
                .up_entry   (up_entry),
                .up_valid   (up_valid),
                .down_valid (down_valid),
                .pass_out   (pass[i+1]),
                .entry      (cell_entry[i]),
                .valid      (cell_valid[i]),
                .match      (cell_match[i]),
                .tail       (cell_tail[i])
            );
        end
    end

    always_comb
    begin
        rsp_next.hit         = hit;
        rsp_next.read_value  = (hit && !is_put) ? hit_value : '0;
        rsp_next.evicted     = !hit && is_put && full;
        rsp_next.evicted_key = (!hit && is_put && full) ? tail_key : '0;

        occupied_next = occupied_reg;
        if (busy_reg && !hit && is_put && !full)
        begin
            occupied_next = occupied_reg + CNT_W'(1);
        end

        capacity_next = capacity_reg;
        if (cfg_we && (occupied_reg == '0))
        begin
            priority if (cfg_wdata == '0)
            begin
                capacity_next = CNT_W'(1);
            end
            else if (int'(cfg_wdata) > CAP)
            begin
                capacity_next = CNT_W'(CAP);
            end
            else
            begin
                capacity_next = CNT_W'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            occupied_reg <= '0;
            capacity_reg <= CNT_W'(CAP_RESET);
        end
        else
        begin
            busy_reg     <= start && !busy_reg;
            done_reg     <= busy_reg;
            occupied_reg <= occupied_next;
            capacity_reg <= capacity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            req_reg <= req;
        end
        if (busy_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== design/lkvc_checker.sv =====
// Port-level checker of the LRU key-value cache and its bind to the top level.
`include "assert_macros.svh"

module lkvc_checker
    import lkvc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input logic  done,
    input rsp_t  rsp
);

    `ASSERT_PROP(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `ASSERT_PROP(a_busy_done, clk, rst_n, busy |=> done)
    `ASSERT_NEVER(a_done_busy, clk, rst_n, done && busy)
    `ASSERT_PROP(a_miss_zero, clk, rst_n, (done && !rsp.hit) |-> (rsp.read_value == '0))
    `ASSERT_NEVER(a_evict_hit, clk, rst_n, done && rsp.evicted && rsp.hit)

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
